/* src/adc_channel_scan_sequencer_assert.svh */
// Assertion macros shared by the scan sequencer RTL.
// Each macro assumes clk and rst_n are visible at the point of use.
`ifndef ADC_CHANNEL_SCAN_SEQUENCER_ASSERT_SVH
`define ADC_CHANNEL_SCAN_SEQUENCER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ACS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ACS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/acs_pkg.sv */
// Types and constants for the ADC channel scan sequencer.
// No dependencies; used by acs_scan and adc_channel_scan_sequencer.
package acs_pkg;

    localparam int CH_W     = 3;
    localparam int CH_SLOTS = 8;
    localparam int RAW_W    = 10;
    localparam int MASK_W   = 6;
    localparam int CNT_W    = 16;
    localparam int PHASE_W  = 3;
    localparam int REG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // Register indexes on the configuration port
    localparam logic [REG_IDX_W-1:0] REG_ENABLE_MASK    = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_SAMPLING_TICKS = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_RESOLUTION     = 2'd2;

    localparam logic [MASK_W-1:0] ENABLE_MASK_RST    = 6'h3F;
    localparam logic [CNT_W-1:0]  SAMPLING_TICKS_RST = 16'd16;

    // Request kinds
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_READ = 1'b1;

    // Phase codes as reported on the result
    localparam logic [PHASE_W-1:0] PHASE_IDLE   = 3'd0;
    localparam logic [PHASE_W-1:0] PHASE_SAMPLE = 3'd1;
    localparam logic [PHASE_W-1:0] PHASE_START  = 3'd2;
    localparam logic [PHASE_W-1:0] PHASE_WAIT   = 3'd3;
    localparam logic [PHASE_W-1:0] PHASE_STORE  = 3'd4;

    typedef enum logic [4:0] {
        PH_IDLE   = 5'b00001,
        PH_SAMPLE = 5'b00010,
        PH_START  = 5'b00100,
        PH_WAIT   = 5'b01000,
        PH_STORE  = 5'b10000
    } scan_phase_t;

    typedef struct packed {
        logic             req_type;
        logic             conv_done;
        logic [RAW_W-1:0] conv_raw;
        logic [CH_W-1:0]  read_channel;
    } cmd_item_t;

    typedef struct packed {
        logic [RAW_W-1:0]   read_value;
        logic               start_conv;
        logic [CH_W-1:0]    mux_channel;
        logic [PHASE_W-1:0] phase;
        logic               sample_stored;
    } res_item_t;

    typedef struct packed {
        logic [MASK_W-1:0] enable_mask;
        logic [CNT_W-1:0]  sampling_ticks;
        logic              resolution_8bit;
    } cfg_t;

    // What one item does to the scan: values after the item plus the buffer write
    typedef struct packed {
        logic               start_conv;
        logic [CH_W-1:0]    channel;
        logic [PHASE_W-1:0] phase;
        logic               store_en;
        logic [CH_W-1:0]    store_addr;
        logic [RAW_W-1:0]   store_data;
    } scan_step_t;

    function automatic logic [PHASE_W-1:0] phase_code(input scan_phase_t ph);
        logic [PHASE_W-1:0] code;
        case (ph)
            PH_IDLE:   code = PHASE_IDLE;
            PH_SAMPLE: code = PHASE_SAMPLE;
            PH_START:  code = PHASE_START;
            PH_WAIT:   code = PHASE_WAIT;
            PH_STORE:  code = PHASE_STORE;
            default:   code = PHASE_IDLE;
        endcase
        return code;
    endfunction

endpackage

/* src/acs_scan.sv */
// Five-phase round-robin scan machine: channel pointer, settle counter, phase.
// Depends on acs_pkg and adc_channel_scan_sequencer_assert.svh.
`include "adc_channel_scan_sequencer_assert.svh"

module acs_scan #(
    parameter int NUM_CHANNELS = 6
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     step_en,
    input  logic                     conv_done,
    input  logic [acs_pkg::RAW_W-1:0] conv_raw,
    input  acs_pkg::cfg_t            cfg,
    output acs_pkg::scan_step_t      step
);
    import acs_pkg::*;

    scan_phase_t       phase_reg, phase_next;
    logic [CH_W-1:0]   chan_reg, chan_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CH_W:0]     chan_inc;
    logic [CH_W-1:0]   chan_wrap;
    logic [CH_SLOTS-1:0] mask_ext;
    logic              chan_on;
    logic              start_now;
    logic              store_now;

    assign chan_inc  = {1'b0, chan_reg} + (CH_W+1)'(1);
    assign chan_wrap = (chan_inc >= (CH_W+1)'(NUM_CHANNELS)) ? '0 : chan_inc[CH_W-1:0];
    // Channels past the mask width have no enable bit and read as off
    assign mask_ext  = CH_SLOTS'(cfg.enable_mask);
    assign chan_on   = mask_ext[chan_wrap];

    always_comb
    begin
        phase_next = phase_reg;
        chan_next  = chan_reg;
        count_next = count_reg;
        start_now  = 1'b0;
        store_now  = 1'b0;
        if (step_en)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    chan_next = chan_wrap;
                    if (chan_on)
                    begin
                        phase_next = PH_SAMPLE;
                        count_next = cfg.sampling_ticks;
                    end
                end
                PH_SAMPLE:
                begin
                    if (count_reg != '0)
                        count_next = count_reg - CNT_W'(1);
                    else
                        phase_next = PH_START;
                end
                PH_START:
                begin
                    start_now  = 1'b1;
                    phase_next = PH_WAIT;
                end
                PH_WAIT:
                begin
                    if (conv_done)
                        phase_next = PH_STORE;
                end
                PH_STORE:
                begin
                    store_now  = 1'b1;
                    phase_next = PH_IDLE;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            chan_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            chan_reg  <= chan_next;
            count_reg <= count_next;
        end
    end

    assign step.start_conv = start_now;
    assign step.channel    = chan_next;
    assign step.phase      = phase_code(phase_next);
    assign step.store_en   = store_now;
    assign step.store_addr = chan_reg;
    // 8-bit mode keeps the high byte of the conversion
    assign step.store_data = cfg.resolution_8bit ? {2'b00, conv_raw[RAW_W-1:2]} : conv_raw;

    `ACS_ASSERT_NEXT(a_start_to_wait, step_en && phase_reg == PH_START,
        phase_reg == PH_WAIT, "start phase did not move to wait")
    `ACS_ASSERT_NEXT(a_hold_without_tick, !step_en,
        $stable(chan_reg) && $stable(phase_reg) && $stable(count_reg),
        "scan state moved without a tick")
    `ACS_ASSERT_NEXT(a_skip_disabled, step_en && phase_reg == PH_IDLE && !chan_on,
        phase_reg == PH_IDLE, "disabled channel left idle")

endmodule

/* src/adc_channel_scan_sequencer.sv */
// Top level of the ADC channel scan sequencer: config registers, result buffer, result queue.
// Depends on acs_pkg, acs_scan and adc_channel_scan_sequencer_assert.svh.
//
//   channel  | direction | handshake              | payload
//   cmd      | in        | cmd_valid / cmd_stall  | acs_pkg::cmd_item_t
//   res      | out       | res_valid / res_stall  | acs_pkg::res_item_t
//   cfg      | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One item per cycle while cmd_stall is low. A taken item's buffer read and metadata register
// in the read stage, which then writes the result into the output queue that drives res.
// Reset clears the scan state and buffer entry valid bits and presets config registers; an entry
// never written reads as zero, so no clearing pass is needed. A stalled result side fills
// the two-entry queue and the read stage, then cmd_stall rises; cfg_ready is always high.
`include "adc_channel_scan_sequencer_assert.svh"

module adc_channel_scan_sequencer #(
    parameter int NUM_CHANNELS = 6
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cmd_valid,
    output logic                            cmd_stall,
    input  acs_pkg::cmd_item_t              cmd,
    output logic                            res_valid,
    input  logic                            res_stall,
    output acs_pkg::res_item_t              res,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [acs_pkg::REG_IDX_W-1:0]   cfg_index,
    input  logic [acs_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import acs_pkg::*;

    localparam int ADDR_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    cfg_t        cfg_reg;
    scan_step_t  step;
    logic        cmd_accept;
    logic        tick_accept;
    logic        rd_in_range;
    logic        rd_en;

    logic [RAW_W-1:0]        store_mem [NUM_CHANNELS];
    logic [RAW_W-1:0]        rdata_reg;
    logic [NUM_CHANNELS-1:0] entry_vld_reg;

    logic        s1_valid_reg;
    logic        s1_hit_reg;
    res_item_t   s1_item_reg;
    res_item_t   s1_item;
    logic        s1_adv;

    res_item_t   queue_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg, count_next;
    logic        res_pop;

    // Configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable_mask     <= ENABLE_MASK_RST;
            cfg_reg.sampling_ticks  <= SAMPLING_TICKS_RST;
            cfg_reg.resolution_8bit <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ENABLE_MASK:    cfg_reg.enable_mask     <= cfg_data[MASK_W-1:0];
                REG_SAMPLING_TICKS: cfg_reg.sampling_ticks  <= cfg_data[CNT_W-1:0];
                REG_RESOLUTION:     cfg_reg.resolution_8bit <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    // Input side: stall whenever the read stage is occupied and the output queue is full
    assign cmd_stall   = s1_valid_reg && (count_reg == 2'd2);
    assign cmd_accept  = cmd_valid && !cmd_stall;
    assign tick_accept = cmd_accept && (cmd.req_type == REQ_TICK);
    assign rd_in_range = (CH_W+1)'(cmd.read_channel) < (CH_W+1)'(NUM_CHANNELS);
    assign rd_en       = cmd_accept && (cmd.req_type == REQ_READ) && rd_in_range;

    acs_scan #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (tick_accept),
        .conv_done (cmd.conv_done),
        .conv_raw  (cmd.conv_raw),
        .cfg       (cfg_reg),
        .step      (step)
    );

    // Result buffer. A write lands at the tick's edge, so a read taken on any later
    // edge already sees it; one item per edge means no same-edge overlap.
    always_ff @(posedge clk)
    begin
        if (step.store_en)
            store_mem[step.store_addr[ADDR_W-1:0]] <= step.store_data;
        if (rd_en)
            rdata_reg <= store_mem[cmd.read_channel[ADDR_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            entry_vld_reg <= '0;
        else if (step.store_en)
            entry_vld_reg[step.store_addr[ADDR_W-1:0]] <= 1'b1;
    end

    // Read stage: hold item metadata while the buffer read completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (cmd_accept)
            s1_valid_reg <= 1'b1;
        else if (s1_adv)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd_accept)
        begin
            s1_hit_reg                <= rd_en && entry_vld_reg[cmd.read_channel[ADDR_W-1:0]];
            s1_item_reg.read_value    <= '0;
            s1_item_reg.start_conv    <= step.start_conv;
            s1_item_reg.mux_channel   <= step.channel;
            s1_item_reg.phase         <= step.phase;
            s1_item_reg.sample_stored <= step.store_en;
        end
    end

    always_comb
    begin
        s1_item            = s1_item_reg;
        s1_item.read_value = s1_hit_reg ? rdata_reg : '0;
    end

    // Output queue
    assign res_valid = (count_reg != 2'd0);
    assign res_pop   = res_valid && !res_stall;
    assign s1_adv    = s1_valid_reg && ((count_reg != 2'd2) || res_pop);
    assign res       = queue_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (s1_adv && !res_pop)
            count_next = count_reg + 2'd1;
        else if (!s1_adv && res_pop)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (s1_adv)
                wr_ptr_reg <= !wr_ptr_reg;
            if (res_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
            queue_reg[wr_ptr_reg] <= s1_item;
    end

    `ACS_ASSERT_NOW(a_no_overwrite, cmd_accept, !s1_valid_reg || s1_adv,
        "item accepted over a held read stage")
    `ACS_ASSERT_NEXT(a_hold_read_stage, s1_valid_reg && !s1_adv, s1_valid_reg && $stable(rdata_reg),
        "held read stage lost its data")
    `ACS_ASSERT_NOW(a_queue_bound, s1_adv && !res_pop, count_reg != 2'd2,
        "push into a full output queue")
    `ACS_ASSERT_NEXT(a_entry_marked, step.store_en,
        entry_vld_reg[$past(step.store_addr[ADDR_W-1:0])], "stored entry not marked valid")

endmodule
